[hw/rtl/sfbw_pkg.sv]
// sfbw_pkg: shared types and constants for the stream to frame buffer writer
// holds the input and result item structs, field widths and the address limit
// no dependencies

package sfbw_pkg;

	localparam int ROW_W   = 11;
	localparam int COL_W   = 11;
	localparam int WIDTH_W = 12;
	localparam int ADDR_W  = 23;
	localparam int WORD_W  = 32;
	localparam int CNT_W   = 12;
	localparam int BEAT_W  = 32;
	localparam int LIM_W   = 26;

	// addresses above this are forced to zero
	localparam logic [LIM_W-1:0] ADDR_LIMIT = 26'd33554432;

	typedef struct packed {
		logic              frame_start;
		logic              line_end;
		logic [ROW_W-1:0]  pixel_row;
		logic [COL_W-1:0]  pixel_col;
		logic [WORD_W-1:0] write_word;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_W-1:0] mem_address;
		logic [WORD_W-1:0] mem_data;
		logic [ROW_W-1:0]  rows_seen;
		logic [CNT_W-1:0]  cols_seen;
		logic [CNT_W-1:0]  widest_row;
		logic [BEAT_W-1:0] beats_written;
	} out_item_t;

	// frame statistics after one item
	typedef struct packed {
		logic [ROW_W-1:0]  rows_seen;
		logic [CNT_W-1:0]  cols_seen;
		logic [CNT_W-1:0]  widest_row;
		logic [BEAT_W-1:0] beats_written;
	} stats_t;

endpackage

[hw/rtl/stream_to_frame_buffer_writer.sv]
// stream_to_frame_buffer_writer: turns stream items into frame buffer writes
// depends on sfbw_pkg, sfbw_addr and sfbw_stats
//
//  port group          dir  handshake            payload
//  in_*                in   in_valid/in_ready    in_item_t (flags, row, column, word)
//  out_*               out  out_valid/out_ready  out_item_t (address, word, statistics)
//  cfg_wr_*            in   cfg_wr_en            12-bit image width
//
// an item passes from acceptance into the input register, then through the
// multiply-add for the address and counter update into the result register
// one item per cycle sustained while out_ready holds; input and result registers
// stay full under a stalled output and in_ready drops only when both hold items
// reset clears the counters, the image width and both valid flags

module stream_to_frame_buffer_writer
	import sfbw_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_item_t           in_data,
	output logic               out_valid,
	input  logic               out_ready,
	output out_item_t          out_data,
	input  logic               cfg_wr_en,
	input  logic [WIDTH_W-1:0] cfg_wr_data
);

	logic [WIDTH_W-1:0] image_width_q;
	logic               valid_s1;
	in_item_t           item_s1;
	logic               adv_s1;
	logic [ADDR_W-1:0]  addr;
	stats_t             stats;

	assign adv_s1   = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= '0;
		end else if (cfg_wr_en) begin
			image_width_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	sfbw_addr u_addr (
		.pixel_row   (item_s1.pixel_row),
		.pixel_col   (item_s1.pixel_col),
		.image_width (image_width_q),
		.mem_address (addr)
	);

	sfbw_stats u_stats (
		.clk         (clk),
		.arst_n      (arst_n),
		.adv         (adv_s1),
		.frame_start (item_s1.frame_start),
		.line_end    (item_s1.line_end),
		.nxt         (stats)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (!out_valid || out_ready) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_data.mem_address   <= addr;
			out_data.mem_data      <= item_s1.write_word;
			out_data.rows_seen     <= stats.rows_seen;
			out_data.cols_seen     <= stats.cols_seen;
			out_data.widest_row    <= stats.widest_row;
			out_data.beats_written <= stats.beats_written;
		end
	end

endmodule

[hw/rtl/sfbw_addr.sv]
// sfbw_addr: word address from row, column and row stride, with limit clamp
// depends on sfbw_pkg

module sfbw_addr
	import sfbw_pkg::*;
(
	input  logic [ROW_W-1:0]   pixel_row,
	input  logic [COL_W-1:0]   pixel_col,
	input  logic [WIDTH_W-1:0] image_width,
	output logic [ADDR_W-1:0]  mem_address
);

	logic [ROW_W+WIDTH_W-1:0] product;
	logic [LIM_W-1:0]         sum;

	always_comb begin
		product = ROW_W'(pixel_row) * image_width;
		sum     = LIM_W'(product) + LIM_W'(pixel_col);
		// clamp cannot fire at the current limit but is kept as a compare
		if (sum > ADDR_LIMIT) begin
			mem_address = '0;
		end else begin
			mem_address = sum[ADDR_W-1:0];
		end
	end

endmodule

[hw/rtl/sfbw_stats.sv]
// sfbw_stats: row, column, widest row and beat counters of the current frame
// updated once per item that leaves the input stage; depends on sfbw_pkg

module sfbw_stats
	import sfbw_pkg::*;
(
	input  logic   clk,
	input  logic   arst_n,
	input  logic   adv,
	input  logic   frame_start,
	input  logic   line_end,
	output stats_t nxt
);

	logic [ROW_W-1:0]  rows_q;
	logic [CNT_W-1:0]  cols_q;
	logic [CNT_W-1:0]  widest_q;
	logic [BEAT_W-1:0] beats_q;
	logic              pending_q;
	logic              pending_nxt;

	always_comb begin
		nxt.rows_seen     = rows_q;
		nxt.cols_seen     = cols_q;
		nxt.widest_row    = widest_q;
		nxt.beats_written = beats_q + BEAT_W'(1);
		pending_nxt       = pending_q;
		if (frame_start) begin
			nxt.rows_seen     = '0;
			nxt.cols_seen     = '0;
			nxt.widest_row    = '0;
			nxt.beats_written = BEAT_W'(1);
			pending_nxt       = 1'b0;
		end else if (pending_q) begin
			// line end seen on the previous item: close the row
			pending_nxt    = 1'b0;
			nxt.rows_seen  = rows_q + ROW_W'(1);
			nxt.cols_seen  = '0;
			if (cols_q > widest_q) begin
				nxt.widest_row = cols_q;
			end
		end else begin
			nxt.cols_seen = cols_q + CNT_W'(1);
			if (line_end) begin
				pending_nxt = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q    <= '0;
			cols_q    <= '0;
			widest_q  <= '0;
			beats_q   <= '0;
			pending_q <= 1'b0;
		end else if (adv) begin
			rows_q    <= nxt.rows_seen;
			cols_q    <= nxt.cols_seen;
			widest_q  <= nxt.widest_row;
			beats_q   <= nxt.beats_written;
			pending_q <= pending_nxt;
		end
	end

	a_frame_start_clears: assert property (@(posedge clk) disable iff (!arst_n)
		adv && frame_start |=> beats_q == BEAT_W'(1) && rows_q == '0 && !pending_q)
		else $error("frame start did not clear the counters");

	a_row_close: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !frame_start && pending_q |=>
			cols_q == '0 && rows_q == ROW_W'($past(rows_q) + ROW_W'(1)) && !pending_q)
		else $error("pending line end did not close the row");

	a_widest_held: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !frame_start && !pending_q |=> $stable(widest_q) && $stable(rows_q))
		else $error("widest row or row count moved inside a row");

endmodule
